// File: hdl/qps_pkg.sv
package qps_pkg;

    localparam int WINDOW_DEPTH_DEF = 4;

    localparam int TIME_W  = 32;
    localparam int POS_W   = 32;
    localparam int SPEED_W = 22;
    localparam int US_W    = 20;

    localparam logic [US_W-1:0] US_PER_S = 20'd1000000;

    localparam int unsigned SPEED_POS_LIMIT = 2097151;
    localparam int unsigned SPEED_NEG_LIMIT = 2097152;

    localparam logic [SPEED_W-1:0] SPEED_MAX_CODE = 22'h1FFFFF;
    localparam logic [SPEED_W-1:0] SPEED_MIN_CODE = 22'h200000;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// File: hdl/qps_window.sv
module qps_window #(
    parameter int WINDOW_DEPTH = qps_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             wr_en,
    input  logic [qps_pkg::POS_W-1:0]        wr_pos,
    input  logic [qps_pkg::TIME_W-1:0]       wr_time,
    output logic [qps_pkg::POS_W-1:0]        rd_pos,
    output logic [qps_pkg::TIME_W-1:0]       rd_time,
    output logic [$clog2(WINDOW_DEPTH+1)-1:0] fill
);

    localparam int HEAD_W = $clog2(WINDOW_DEPTH);
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);

    logic [qps_pkg::POS_W-1:0]  mem_pos  [WINDOW_DEPTH];
    logic [qps_pkg::TIME_W-1:0] mem_time [WINDOW_DEPTH];

    logic [HEAD_W-1:0] head_reg, head_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W:0]   oldest_wide;
    logic [HEAD_W-1:0] oldest;

    // oldest live entry, modulo the window depth
    always_comb begin
        if ((FILL_W + 1)'(head_reg) >= (FILL_W + 1)'(fill_reg)) begin
            oldest_wide = (FILL_W + 1)'(head_reg) - (FILL_W + 1)'(fill_reg);
        end else begin
            oldest_wide = (FILL_W + 1)'(head_reg) + (FILL_W + 1)'(WINDOW_DEPTH)
                          - (FILL_W + 1)'(fill_reg);
        end
        oldest = oldest_wide[HEAD_W-1:0];
    end

    always_comb begin
        head_next = head_reg;
        fill_next = fill_reg;
        if (wr_en) begin
            if (head_reg == HEAD_W'(WINDOW_DEPTH - 1)) begin
                head_next = '0;
            end else begin
                head_next = head_reg + HEAD_W'(1);
            end
            if (fill_reg != FILL_W'(WINDOW_DEPTH)) begin
                fill_next = fill_reg + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            fill_reg <= '0;
        end else begin
            head_reg <= head_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_pos[head_reg]  <= wr_pos;
            mem_time[head_reg] <= wr_time;
        end
        rd_pos  <= mem_pos[oldest];
        rd_time <= mem_time[oldest];
    end

    assign fill = fill_reg;

endmodule

// File: hdl/qps_divider.sv
module qps_divider #(
    parameter int NUM_W = 22
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [NUM_W-1:0]            numer,
    input  logic [qps_pkg::TIME_W-1:0]  denom,
    output logic [NUM_W-1:0]            quot,
    output qps_pkg::div_stat_t          stat
);

    localparam int DEN_W = qps_pkg::TIME_W;
    localparam int CNT_W = $clog2(NUM_W);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;

    logic [DEN_W:0] rem_sh;
    logic [DEN_W:0] rem_sub;
    logic           fits;

    // one restoring step per cycle
    always_comb begin
        rem_sh  = {rem_reg, quo_reg[NUM_W-1]};
        fits    = rem_sh >= {1'b0, den_reg};
        rem_sub = rem_sh - {1'b0, den_reg};
    end

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = '0;
            quo_next  = numer;
            den_next  = denom;
            cnt_next  = CNT_W'(NUM_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign quot      = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && (cnt_reg == '0);

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider started while busy");

endmodule

// File: hdl/quadrature_position_speed.sv
// flow: a request is taken in idle and passes the read, prep and multiply states, then
// the divide state, where the bit-serial divider makes one quotient bit per cycle; a
// request whose speed is zero by rule (short window or tiny time span) skips the divide
// state; s_ready is low while a request is in work, and the done state waits on m_ready
// reset: synchronous active-low aresetn clears levels, position, window fill and head,
// the invert setting and all handshake state
module quadrature_position_speed #(
    parameter int WINDOW_DEPTH = qps_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_data,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_edge_channel,
    input  logic                              s_edge_level,
    input  logic [qps_pkg::TIME_W-1:0]        s_edge_time_us,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [qps_pkg::POS_W-1:0]  m_position_count,
    output logic signed [qps_pkg::SPEED_W-1:0] m_speed_counts_per_s
);

    localparam int POS_W   = qps_pkg::POS_W;
    localparam int TIME_W  = qps_pkg::TIME_W;
    localparam int SPEED_W = qps_pkg::SPEED_W;
    localparam int FILL_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int DPOS_W  = $clog2(WINDOW_DEPTH);
    localparam int NUM_W   = DPOS_W + qps_pkg::US_W;
    localparam int QX_W    = ((NUM_W > SPEED_W) ? NUM_W : SPEED_W) + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_PREP,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    logic              invert_reg, invert_next;
    logic              level_a_reg, level_a_next;
    logic              level_b_reg, level_b_next;
    logic [POS_W-1:0]  position_reg, position_next;
    logic [TIME_W-1:0] time_new_reg, time_new_next;
    logic [TIME_W-1:0] dt_reg, dt_next;
    logic [DPOS_W-1:0] mag_reg, mag_next;
    logic              neg_reg, neg_next;
    logic              zero_reg, zero_next;

    logic               m_valid_reg, m_valid_next;
    logic [POS_W-1:0]   m_pos_reg, m_pos_next;
    logic [SPEED_W-1:0] m_speed_reg, m_speed_next;

    logic              accept;
    logic              same;
    logic              step_down;
    logic [POS_W-1:0]  pos_stepped;
    logic [POS_W-1:0]  rd_pos;
    logic [TIME_W-1:0] rd_time;
    logic [FILL_W-1:0] fill;
    logic [POS_W-1:0]  dpos;
    logic [TIME_W-1:0] dt;
    logic [POS_W-1:0]  dpos_abs;
    logic [NUM_W-1:0]  numer;
    logic              div_start;
    logic [NUM_W-1:0]  quot;
    logic [QX_W-1:0]   quot_x;
    logic [SPEED_W-1:0] speed;

    qps_pkg::div_stat_t div_stat;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // direction from the level of the other line
    always_comb begin
        if (s_edge_channel) begin
            same      = (level_a_reg == s_edge_level);
            step_down = !(same ^ invert_reg);
        end else begin
            same      = (level_b_reg == s_edge_level);
            step_down = same ^ invert_reg;
        end
        pos_stepped = step_down ? position_reg - POS_W'(1) : position_reg + POS_W'(1);
    end

    qps_window #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (accept),
        .wr_pos  (pos_stepped),
        .wr_time (s_edge_time_us),
        .rd_pos  (rd_pos),
        .rd_time (rd_time),
        .fill    (fill)
    );

    always_comb begin
        dpos     = position_reg - rd_pos;
        dt       = time_new_reg - rd_time;
        dpos_abs = dpos[POS_W-1] ? (~dpos + POS_W'(1)) : dpos;
        numer    = NUM_W'(mag_reg) * NUM_W'(qps_pkg::US_PER_S);
    end

    assign div_start = (state_reg == ST_MUL) && !zero_reg;

    qps_divider #(
        .NUM_W (NUM_W)
    ) u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (numer),
        .denom   (dt_reg),
        .quot    (quot),
        .stat    (div_stat)
    );

    // sign and saturation
    always_comb begin
        quot_x = QX_W'(quot);
        if (zero_reg) begin
            speed = '0;
        end else if (!neg_reg) begin
            if (quot_x > QX_W'(qps_pkg::SPEED_POS_LIMIT)) begin
                speed = qps_pkg::SPEED_MAX_CODE;
            end else begin
                speed = quot_x[SPEED_W-1:0];
            end
        end else begin
            if (quot_x > QX_W'(qps_pkg::SPEED_NEG_LIMIT)) begin
                speed = qps_pkg::SPEED_MIN_CODE;
            end else begin
                speed = ~quot_x[SPEED_W-1:0] + SPEED_W'(1);
            end
        end
    end

    always_comb begin
        state_next    = state_reg;
        invert_next   = invert_reg;
        level_a_next  = level_a_reg;
        level_b_next  = level_b_reg;
        position_next = position_reg;
        time_new_next = time_new_reg;
        dt_next       = dt_reg;
        mag_next      = mag_reg;
        neg_next      = neg_reg;
        zero_next     = zero_reg;
        m_valid_next  = m_valid_reg;
        m_pos_next    = m_pos_reg;
        m_speed_next  = m_speed_reg;

        if (cfg_valid && cfg_ready) begin
            invert_next = cfg_data;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_edge_channel) begin
                        level_b_next = s_edge_level;
                    end else begin
                        level_a_next = s_edge_level;
                    end
                    position_next = pos_stepped;
                    time_new_next = s_edge_time_us;
                    state_next    = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_PREP;
            end
            ST_PREP: begin
                dt_next    = dt;
                neg_next   = dpos[POS_W-1];
                mag_next   = dpos_abs[DPOS_W-1:0];
                zero_next  = (fill < FILL_W'(2)) || (dt <= TIME_W'(1));
                state_next = ST_MUL;
            end
            ST_MUL: begin
                state_next = zero_reg ? ST_DONE : ST_DIV;
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_pos_next   = position_reg;
                    m_speed_next = speed;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            invert_reg   <= 1'b0;
            level_a_reg  <= 1'b0;
            level_b_reg  <= 1'b0;
            position_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            invert_reg   <= invert_next;
            level_a_reg  <= level_a_next;
            level_b_reg  <= level_b_next;
            position_reg <= position_next;
            m_valid_reg  <= m_valid_next;
        end
        time_new_reg <= time_new_next;
        dt_reg       <= dt_next;
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        zero_reg     <= zero_next;
        m_pos_reg    <= m_pos_next;
        m_speed_reg  <= m_speed_next;
    end

    assign m_valid              = m_valid_reg;
    assign m_position_count     = $signed(m_pos_reg);
    assign m_speed_counts_per_s = $signed(m_speed_reg);

    a_request_to_read: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_READ)
        else $error("request not followed by window read");

    a_step_one: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (position_reg == $past(position_reg) + POS_W'(1))
                || (position_reg == $past(position_reg) - POS_W'(1)))
        else $error("position moved by other than one count");

    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> state_reg == ST_DIV)
        else $error("divider finished outside divide state");

    a_zero_skips_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL) && zero_reg |=> !div_stat.busy && state_reg == ST_DONE)
        else $error("zero speed request reached the divider");

endmodule

// File: tb/sv/quadrature_position_speed_tb.sv
module quadrature_position_speed_tb;

    localparam int  DEPTH  = qps_pkg::WINDOW_DEPTH_DEF;
    localparam bit  LINE_A = 1'b0;
    localparam bit  LINE_B = 1'b1;

    class encoder_speed_tracker;
        bit                           invert;
        bit                           line_a;
        bit                           line_b;
        logic [qps_pkg::POS_W-1:0]    count;
        logic [qps_pkg::POS_W-1:0]    hist_pos[DEPTH];
        logic [qps_pkg::TIME_W-1:0]   hist_tick[DEPTH];
        int                           fill;
        int                           head;
        logic [qps_pkg::POS_W-1:0]    due_position[$];
        logic [qps_pkg::SPEED_W-1:0]  due_speed[$];
        int                           errors;

        function new();
            invert = 1'b0;
            line_a = 1'b0;
            line_b = 1'b0;
            count  = '0;
            fill   = 0;
            head   = 0;
            errors = 0;
        endfunction

        function void set_invert(bit v);
            invert = v;
        endfunction

        function int pending();
            return due_position.size();
        endfunction

        function logic [qps_pkg::SPEED_W-1:0] window_rate();
            int                         newest;
            int                         oldest;
            logic [qps_pkg::TIME_W-1:0] span_t;
            logic [qps_pkg::POS_W-1:0]  span_p;
            longint                     q;
            if (fill < 2)
                return '0;
            newest = (head + DEPTH - 1) % DEPTH;
            oldest = (newest + DEPTH - (fill - 1)) % DEPTH;
            span_t = hist_tick[newest] - hist_tick[oldest];
            if (span_t <= 1)
                return '0;
            span_p = hist_pos[newest] - hist_pos[oldest];
            // signed division truncates toward zero
            q = (longint'($signed(span_p)) * longint'(qps_pkg::US_PER_S))
                / longint'({32'b0, span_t});
            if (q > longint'(qps_pkg::SPEED_POS_LIMIT))
                q = longint'(qps_pkg::SPEED_POS_LIMIT);
            if (q < -longint'(qps_pkg::SPEED_NEG_LIMIT))
                q = -longint'(qps_pkg::SPEED_NEG_LIMIT);
            return q[qps_pkg::SPEED_W-1:0];
        endfunction

        function void note_edge(bit ch, bit lvl, logic [qps_pkg::TIME_W-1:0] tick);
            bit same;
            if (ch == LINE_A) begin
                line_a = lvl;
                same   = (line_b == lvl);
                if (same != invert)
                    count = count - 1;
                else
                    count = count + 1;
            end else begin
                line_b = lvl;
                same   = (line_a == lvl);
                if (same != invert)
                    count = count + 1;
                else
                    count = count - 1;
            end
            hist_pos[head]  = count;
            hist_tick[head] = tick;
            head = (head + 1) % DEPTH;
            if (fill < DEPTH)
                fill++;
            due_position.push_back(count);
            due_speed.push_back(window_rate());
        endfunction

        function void check_reading(logic [qps_pkg::POS_W-1:0] pos,
                                    logic [qps_pkg::SPEED_W-1:0] spd);
            logic [qps_pkg::POS_W-1:0]   want_pos;
            logic [qps_pkg::SPEED_W-1:0] want_spd;
            if (due_position.size() == 0) begin
                $display("%0t: result with no request outstanding: position %0d speed %0d",
                         $time, $signed(pos), $signed(spd));
                errors++;
                return;
            end
            want_pos = due_position.pop_front();
            want_spd = due_speed.pop_front();
            if (pos !== want_pos) begin
                $display("%0t: position mismatch: expected %0d actual %0d",
                         $time, $signed(want_pos), $signed(pos));
                errors++;
            end
            if (spd !== want_spd) begin
                $display("%0t: speed mismatch: expected %0d actual %0d",
                         $time, $signed(want_spd), $signed(spd));
                errors++;
            end
        endfunction
    endclass

    logic                               aclk = 1'b0;
    logic                               aresetn = 1'b0;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic                               cfg_data = 1'b0;
    logic                               s_valid = 1'b0;
    logic                               s_ready;
    logic                               s_edge_channel = 1'b0;
    logic                               s_edge_level = 1'b0;
    logic [qps_pkg::TIME_W-1:0]         s_edge_time_us = '0;
    logic                               m_valid;
    logic                               m_ready = 1'b0;
    logic signed [qps_pkg::POS_W-1:0]   m_position_count;
    logic signed [qps_pkg::SPEED_W-1:0] m_speed_counts_per_s;

    encoder_speed_tracker tracker;
    bit                   no_idle = 1'b0;
    bit                   tail_run = 1'b0;
    bit                   hold_req = 1'b0;
    bit                   enc_a = 1'b0;
    bit                   enc_b = 1'b0;

    always #5 aclk = ~aclk;

    quadrature_position_speed u_top (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_data             (cfg_data),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_edge_channel       (s_edge_channel),
        .s_edge_level         (s_edge_level),
        .s_edge_time_us       (s_edge_time_us),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_position_count     (m_position_count),
        .m_speed_counts_per_s (m_speed_counts_per_s)
    );

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                tracker.set_invert(cfg_data);
            if (s_valid && s_ready)
                tracker.note_edge(s_edge_channel, s_edge_level, s_edge_time_us);
            if (m_valid && m_ready)
                tracker.check_reading(m_position_count, m_speed_counts_per_s);
        end
    end

    // result side: random stalls plus one long hold-off on request
    initial begin
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
            end else if (!no_idle && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    task automatic send_edge(bit ch, bit lvl, logic [qps_pkg::TIME_W-1:0] tick);
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_edge_channel <= ch;
        s_edge_level   <= lvl;
        s_edge_time_us <= tick;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if (ch == LINE_A)
            enc_a = lvl;
        else
            enc_b = lvl;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do
            @(posedge aclk);
        while (tracker.pending() != 0);
    endtask

    task automatic write_invert(bit v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // mostly clean quadrature walks in runs, with some noise edges
    task automatic random_phase(int n_items, bit with_hold, bit with_pause);
        int                         sent;
        int                         run_left;
        int                         style;
        bit                         fwd;
        bit                         ch;
        bit                         lvl;
        logic [qps_pkg::TIME_W-1:0] tick;
        sent     = 0;
        run_left = 0;
        style    = 0;
        fwd      = 1'b0;
        tick     = $urandom;
        while (sent < n_items) begin
            if (!tail_run && sent % 50 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            if (run_left == 0) begin
                run_left = $urandom_range(4, 40);
                fwd      = 1'($urandom_range(0, 1));
                style    = $urandom_range(0, 9);
            end
            if ($urandom_range(0, 9) == 0) begin
                ch   = 1'($urandom_range(0, 1));
                lvl  = 1'($urandom_range(0, 1));
                tick = $urandom;
            end else begin
                case (style)
                    0:       tick = tick + $urandom_range(0, 1);
                    6, 7:    tick = tick + $urandom_range(0, 100000);
                    8:       tick = tick + $urandom;
                    9:       tick = tick + 7;
                    default: tick = tick + $urandom_range(2, 200);
                endcase
                if ((enc_a == enc_b) == fwd) begin
                    ch  = LINE_A;
                    lvl = ~enc_a;
                end else begin
                    ch  = LINE_B;
                    lvl = ~enc_b;
                end
            end
            send_edge(ch, lvl, tick);
            sent++;
            run_left--;
            if (with_hold && sent == n_items / 3)
                hold_req = 1'b1;
            if (with_pause && sent == n_items / 2)
                wait_drained();
        end
    endtask

    initial begin
        tracker = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_invert(1'b0);
        // short window, tiny spans, highest speed the window allows
        send_edge(LINE_A, 1'b1, 32'd0);
        send_edge(LINE_B, 1'b1, 32'd1);
        send_edge(LINE_A, 1'b0, 32'd1);
        send_edge(LINE_B, 1'b0, 32'd1);
        send_edge(LINE_A, 1'b1, 32'd1);
        send_edge(LINE_B, 1'b1, 32'd3);
        send_edge(LINE_A, 1'b0, 32'd4);
        send_edge(LINE_B, 1'b0, 32'd5);
        // reverse walk, negative speed truncated toward zero
        send_edge(LINE_B, 1'b1, 32'd12);
        send_edge(LINE_A, 1'b1, 32'd19);
        send_edge(LINE_B, 1'b0, 32'd26);
        send_edge(LINE_A, 1'b0, 32'd33);
        send_edge(LINE_B, 1'b1, 32'd40);
        // timestamp extremes and wrap
        send_edge(LINE_A, 1'b1, 32'hFFFF_FFF0);
        send_edge(LINE_B, 1'b0, 32'hFFFF_FFFF);
        send_edge(LINE_A, 1'b0, 32'h0000_0002);
        send_edge(LINE_B, 1'b1, 32'h0000_0005);
        send_edge(LINE_A, 1'b1, 32'h8000_0000);
        // repeated level on the same line
        send_edge(LINE_A, 1'b1, 32'h8000_0003);
        send_edge(LINE_B, 1'b1, 32'h8000_0009);
        send_edge(LINE_B, 1'b1, 32'h7FFF_FFFF);

        write_invert(1'b1);
        random_phase(295, 1'b1, 1'b0);
        write_invert(1'b0);
        random_phase(295, 1'b0, 1'b1);
        write_invert(1'b1);
        random_phase(295, 1'b0, 1'b0);
        write_invert(1'b0);
        no_idle  = 1'b1;
        tail_run = 1'b1;
        random_phase(295, 1'b0, 1'b0);
        no_idle = 1'b1;

        wait_drained();
        repeat (40) @(posedge aclk);
        if (tracker.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #5000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// File: quadrature_position_speed.f
hdl/qps_pkg.sv
hdl/qps_window.sv
hdl/qps_divider.sv
hdl/quadrature_position_speed.sv
tb/sv/quadrature_position_speed_tb.sv
